[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the spring direction projection block.
// No dependencies; the including module must have clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SDP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the module clock and reset.
`define SDP_ASSERT(lbl, prop, msg) `SDP_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/sdp_pkg.sv]
// Shared constants for the spring direction projection block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdp_pkg;

  localparam int unsigned WordBitsDef = 32;
  // Extra fraction bits carried on the norm before the division.
  localparam int unsigned GuardBits   = 14;

endpackage
`default_nettype wire

[hw/rtl/sdp_in_if.sv]
// Input channel of the spring direction projection block: one spring per beat.
// Depends on sdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface sdp_in_if
  import sdp_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] first_x;
  logic signed [WORD_BITS-1:0] first_y;
  logic signed [WORD_BITS-1:0] first_z;
  logic signed [WORD_BITS-1:0] second_x;
  logic signed [WORD_BITS-1:0] second_y;
  logic signed [WORD_BITS-1:0] second_z;
  logic        [WORD_BITS-2:0] rest_length;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z, rest_length,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z, rest_length,
    output ready
  );
endinterface
`default_nettype wire

[hw/rtl/sdp_out_if.sv]
// Output channel of the spring direction projection block: one vector per beat.
// Depends on sdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface sdp_out_if
  import sdp_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] dir_x;
  logic signed [WORD_BITS-1:0] dir_y;
  logic signed [WORD_BITS-1:0] dir_z;
  logic                        degenerate;

  modport source (
    output valid, dir_x, dir_y, dir_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, dir_x, dir_y, dir_z, degenerate,
    output ready
  );
endinterface
`default_nettype wire

[hw/rtl/sdp_sqrt_cell.sv]
// One cell of the square root chain: resolves one root bit per cell.
// Depends on sdp_pkg; instantiated by spring_direction_projection.
`timescale 1ns / 1ps
`default_nettype none
module sdp_sqrt_cell
  import sdp_pkg::*;
#(
  parameter int unsigned RADW = 96,
  parameter int unsigned RW   = 48,
  parameter int unsigned PW   = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [RADW-1:0] rad_i,
  input  wire logic [RW+1:0]   rem_i,
  input  wire logic [RW-1:0]   root_i,
  input  wire logic [PW-1:0]   pay_i,
  output logic                 valid_o,
  output logic      [RADW-1:0] rad_o,
  output logic      [RW+1:0]   rem_o,
  output logic      [RW-1:0]   root_o,
  output logic      [PW-1:0]   pay_o
);
  logic            valid_q;
  logic [RADW-1:0] rad_q, rad_d;
  logic [RW+1:0]   rem_q, rem_d, pre, trial;
  logic [RW-1:0]   root_q, root_d;
  logic [PW-1:0]   pay_q;
  logic            ge;

  always_comb begin
    // bring down the next two radicand bits and try root*4+1
    pre    = {rem_i[RW-1:0], rad_i[RADW-1 -: 2]};
    trial  = {root_i, 2'b01};
    ge     = (pre >= trial);
    rem_d  = ge ? (pre - trial) : pre;
    root_d = {root_i[RW-2:0], ge};
    rad_d  = {rad_i[RADW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      pay_q  <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pay_o   = pay_q;
endmodule
`default_nettype wire

[hw/rtl/sdp_div_cell.sv]
// One cell of the divider chain: one quotient bit for each of the three axes.
// Depends on sdp_pkg; instantiated by spring_direction_projection.
`timescale 1ns / 1ps
`default_nettype none
module sdp_div_cell
  import sdp_pkg::*;
#(
  parameter int unsigned RW = 48,
  parameter int unsigned QB = 32,
  parameter int unsigned PW = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [RW-1:0]        den_i,
  input  wire logic [2:0][RW-1:0]   rem_i,
  input  wire logic [2:0][QB-1:0]   lo_i,
  input  wire logic [PW-1:0]        pay_i,
  output logic                      valid_o,
  output logic      [RW-1:0]        den_o,
  output logic      [2:0][RW-1:0]   rem_o,
  output logic      [2:0][QB-1:0]   lo_o,
  output logic      [PW-1:0]        pay_o
);
  logic                 valid_q;
  logic [RW-1:0]        den_q;
  logic [2:0][RW-1:0]   rem_q, rem_d;
  logic [2:0][QB-1:0]   lo_q, lo_d;
  logic [PW-1:0]        pay_q;
  logic [2:0][RW:0]     sh, diff;
  logic [2:0]           ge;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      // shift in the next dividend bit; the freed low bit takes the quotient bit
      sh[l]    = {rem_i[l], lo_i[l][QB-1]};
      diff[l]  = sh[l] - {1'b0, den_i};
      ge[l]    = (sh[l] >= {1'b0, den_i});
      rem_d[l] = ge[l] ? diff[l][RW-1:0] : sh[l][RW-1:0];
      lo_d[l]  = {lo_i[l][QB-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= den_i;
      rem_q <= rem_d;
      lo_q  <= lo_d;
      pay_q <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign lo_o    = lo_q;
  assign pay_o   = pay_q;
endmodule
`default_nettype wire

[hw/rtl/sdp_out_buf.sv]
// Two-entry output buffer that decouples the pipeline from the result channel.
// Depends on sdp_pkg; instantiated by spring_direction_projection.
`timescale 1ns / 1ps
`default_nettype none
module sdp_out_buf
  import sdp_pkg::*;
#(
  parameter int unsigned DW = 97
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] data_i,
  input  wire logic          ready_i,
  output logic               valid_o,
  output logic      [DW-1:0] data_o,
  output logic               full_o
);
  logic [1:0]    cnt_q, cnt_d;
  logic [DW-1:0] e0_q, e1_q;
  logic          pop;

  assign pop     = (cnt_q != 2'd0) && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = e0_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      // advance head; a new beat lands behind whatever remains
      if (push_i) begin
        if (cnt_q == 2'd1) begin
          e0_q <= data_i;
        end else begin
          e0_q <= e1_q;
          e1_q <= data_i;
        end
      end else begin
        e0_q <= e1_q;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        e0_q <= data_i;
      end else begin
        e1_q <= data_i;
      end
    end
  end
endmodule
`default_nettype wire

[hw/rtl/spring_direction_projection.sv]
// Channel     | dir | beat contents
// spring_i    | in  | first_x/y/z, second_x/y/z, rest_length
// dir_o       | out | dir_x/y/z, degenerate
//
// One spring per cycle sustained while the output buffer has room; the path runs
// through the input, square and sum stages, the square root chain (RW = WORD_BITS + 16
// cells, one root bit each) and the divider chain (WORD_BITS cells).
// A two-entry output buffer holds finished vectors; the whole chain stalls
// only when both entries are occupied. Reset clears valid bits and the buffer.
// Depends on sdp_pkg, sdp_in_if, sdp_out_if, the cells, sdp_out_buf.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module spring_direction_projection
  import sdp_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sdp_in_if.sink     spring_i,
  sdp_out_if.source  dir_o
);
  localparam int unsigned W    = WORD_BITS;
  localparam int unsigned MW   = W + 1;
  localparam int unsigned SQW  = 2 * MW;
  localparam int unsigned SW   = SQW + 2;
  localparam int unsigned RADW = SW + 2 * GuardBits;
  localparam int unsigned RW   = RADW / 2;
  localparam int unsigned QB   = W;
  localparam int unsigned PRW  = 2 * W;
  localparam int unsigned NUMW = PRW + GuardBits;
  localparam int unsigned SPW  = 3 * NUMW + 4;
  localparam int unsigned DPW  = 4;
  localparam int unsigned ODW  = 3 * W + 1;
  localparam logic [QB:0] NegLim = (QB + 1)'(1) << (W - 1);
  localparam logic [QB:0] PosLim = NegLim - (QB + 1)'(1);

  logic en, buf_full, push;

  assign en             = !buf_full;
  assign spring_i.ready = en;

  // input stage: differences and magnitudes
  logic [2:0][W-1:0]  fst, snd;
  logic [2:0][W:0]    diff;
  logic [2:0][MW-1:0] mag_d;
  logic               v0_q;
  logic [2:0][MW-1:0] mag0_q;
  logic [2:0]         neg0_q;
  logic [W-2:0]       r0_q;

  assign fst = {spring_i.first_z, spring_i.first_y, spring_i.first_x};
  assign snd = {spring_i.second_z, spring_i.second_y, spring_i.second_x};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      diff[l]  = {fst[l][W-1], fst[l]} - {snd[l][W-1], snd[l]};
      mag_d[l] = diff[l][W] ? (~diff[l] + MW'(1)) : diff[l];
    end
  end

  // stage 1: squares and rest length products; stage 2: sum of squares
  logic                v1_q, v2_q;
  logic [2:0][SQW-1:0] sq1_q;
  logic [2:0][PRW-1:0] prod1_q;
  logic [2:0]          neg1_q;
  logic [SW-1:0]       sum;
  logic [RADW-1:0]     rad2_q;
  logic [SPW-1:0]      pay2_q;

  assign sum = SW'(sq1_q[0]) + SW'(sq1_q[1]) + SW'(sq1_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= spring_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag0_q <= mag_d;
      for (int l = 0; l < 3; l++) begin
        neg0_q[l]  <= diff[l][W];
        sq1_q[l]   <= SQW'(mag0_q[l]) * SQW'(mag0_q[l]);
        prod1_q[l] <= PRW'(r0_q) * PRW'(mag0_q[l]);
      end
      r0_q   <= spring_i.rest_length;
      neg1_q <= neg0_q;
      rad2_q <= {sum, {(2 * GuardBits){1'b0}}};
      pay2_q <= {prod1_q[2], {GuardBits{1'b0}}, prod1_q[1], {GuardBits{1'b0}},
                 prod1_q[0], {GuardBits{1'b0}}, neg1_q, (sum == '0)};
    end
  end

  // square root chain
  logic [RW:0]               sv;
  logic [RW:0][RADW-1:0]     srad;
  logic [RW:0][RW+1:0]       srem;
  logic [RW:0][RW-1:0]       sroot;
  logic [RW:0][SPW-1:0]      spay;

  assign sv[0]    = v2_q;
  assign srad[0]  = rad2_q;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign spay[0]  = pay2_q;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    sdp_sqrt_cell #(.RADW(RADW), .RW(RW), .PW(SPW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv[k]),
      .rad_i   (srad[k]),
      .rem_i   (srem[k]),
      .root_i  (sroot[k]),
      .pay_i   (spay[k]),
      .valid_o (sv[k+1]),
      .rad_o   (srad[k+1]),
      .rem_o   (srem[k+1]),
      .root_o  (sroot[k+1]),
      .pay_o   (spay[k+1])
    );
  end

  // divider chain: dividend high part seeds the remainder, low part shifts out
  logic [QB:0]                dv;
  logic [QB:0][RW-1:0]        dden;
  logic [QB:0][2:0][RW-1:0]   drem;
  logic [QB:0][2:0][QB-1:0]   dlo;
  logic [QB:0][DPW-1:0]       dpay;
  logic [2:0][NUMW-1:0]       num;

  for (genvar l = 0; l < 3; l++) begin : g_seed
    assign num[l]     = spay[RW][4 + l * NUMW +: NUMW];
    assign drem[0][l] = RW'(num[l][NUMW-1:QB]);
    assign dlo[0][l]  = num[l][QB-1:0];
  end

  assign dv[0]   = sv[RW];
  assign dden[0] = sroot[RW];
  assign dpay[0] = spay[RW][3:0];

  for (genvar k = 0; k < QB; k++) begin : g_div
    sdp_div_cell #(.RW(RW), .QB(QB), .PW(DPW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[k]),
      .den_i   (dden[k]),
      .rem_i   (drem[k]),
      .lo_i    (dlo[k]),
      .pay_i   (dpay[k]),
      .valid_o (dv[k+1]),
      .den_o   (dden[k+1]),
      .rem_o   (drem[k+1]),
      .lo_o    (dlo[k+1]),
      .pay_o   (dpay[k+1])
    );
  end

  // round half up, saturate, apply sign
  logic [2:0][QB:0]  m, msat;
  logic [2:0][W-1:0] dir;
  logic              degen;
  logic [ODW-1:0]    obuf_d, obuf_q;

  assign degen = dpay[QB][0];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      m[l] = {1'b0, dlo[QB][l]}
           + (QB + 1)'({drem[QB][l], 1'b0} >= {1'b0, dden[QB]});
      if (dpay[QB][l + 1]) begin
        msat[l] = (m[l] > NegLim) ? NegLim : m[l];
        dir[l]  = W'(~msat[l] + (QB + 1)'(1));
      end else begin
        msat[l] = (m[l] > PosLim) ? PosLim : m[l];
        dir[l]  = W'(msat[l]);
      end
      if (degen) begin
        dir[l] = '0;
      end
    end
  end

  assign obuf_d = {degen, dir[2], dir[1], dir[0]};
  assign push   = dv[QB] && en;

  sdp_out_buf #(.DW(ODW)) u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (obuf_d),
    .ready_i (dir_o.ready),
    .valid_o (dir_o.valid),
    .data_o  (obuf_q),
    .full_o  (buf_full)
  );

  assign dir_o.dir_x      = obuf_q[W-1:0];
  assign dir_o.dir_y      = obuf_q[2*W-1:W];
  assign dir_o.dir_z      = obuf_q[3*W-1:2*W];
  assign dir_o.degenerate = obuf_q[3*W];

  `SDP_ASSERT(a_degen_zero, (dir_o.valid && dir_o.degenerate) |-> (dir_o.dir_x == '0 && dir_o.dir_y == '0 && dir_o.dir_z == '0), "degenerate beat with nonzero vector")
  `SDP_ASSERT(a_stall_has_result, !spring_i.ready |-> dir_o.valid, "input stalled with no result waiting")
  `SDP_ASSERT(a_full_pop_keeps, (buf_full && dir_o.valid && dir_o.ready) |=> dir_o.valid, "second buffered result lost after pop")
endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for spring_direction_projection: streams springs and checks vectors.
// Depends on sdp_pkg, sdp_in_if, sdp_out_if and the block's RTL.
`timescale 1ns / 1ps
module testbench;
  import sdp_pkg::*;

  localparam int unsigned W = WordBitsDef;
  localparam int unsigned NUM_RANDOM = 1730;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [W-1:0] ax, ay, az, bx, by, bz;
    logic [W-2:0] rest;
  } spring_t;

  typedef struct packed {
    logic signed [W-1:0] dx, dy, dz;
    logic degen;
  } vec_t;

  class dir_scoreboard;
    vec_t expected_q[$];
    int errors;
    int checked;
    int degen_seen;

    function new();
      errors = 0;
      checked = 0;
      degen_seen = 0;
    endfunction

    // Root of x, truncated.
    function automatic logic [127:0] root_floor(logic [127:0] x);
      logic [127:0] r, c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (128'd1 << b);
        if (c * c <= x) r = c;
      end
      return r;
    endfunction

    function automatic vec_t project(spring_t s);
      logic signed [W:0] p[3];
      logic [127:0] mag[3], sq, norm, num, q, rem;
      logic [W-1:0] d[3];
      vec_t v;
      p[0] = $signed({s.ax[W-1], s.ax}) - $signed({s.bx[W-1], s.bx});
      p[1] = $signed({s.ay[W-1], s.ay}) - $signed({s.by[W-1], s.by});
      p[2] = $signed({s.az[W-1], s.az}) - $signed({s.bz[W-1], s.bz});
      sq = '0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = 128'(p[i][W] ? -p[i] : p[i]);
        mag[i] = mag[i] & ((128'd1 << (W + 1)) - 1);
        sq = sq + mag[i] * mag[i];
      end
      if (sq == 0) begin
        v.dx = '0; v.dy = '0; v.dz = '0; v.degen = 1'b1;
        return v;
      end
      norm = root_floor(sq << (2 * GuardBits));
      for (int i = 0; i < 3; i++) begin
        num = (128'(s.rest) * mag[i]) << GuardBits;
        q = num / norm;
        rem = num % norm;
        if (rem >= norm - rem) q = q + 1;
        if (p[i][W]) begin
          if (q > (128'd1 << (W - 1))) q = 128'd1 << (W - 1);
          d[i] = W'(-q);
        end else begin
          if (q > (128'd1 << (W - 1)) - 1) q = (128'd1 << (W - 1)) - 1;
          d[i] = W'(q);
        end
      end
      v.dx = d[0]; v.dy = d[1]; v.dz = d[2]; v.degen = 1'b0;
      return v;
    endfunction

    function void note_spring(spring_t s);
      expected_q = {expected_q, project(s)};
    endfunction

    function void check_vector(vec_t got);
      vec_t exp_v;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected vector %h", $time, got);
        errors++;
        return;
      end
      exp_v = expected_q.pop_front();
      checked++;
      if (got.degen) degen_seen++;
      if (got.dx !== exp_v.dx) begin
        $display("%0t: dir_x exp %h got %h", $time, exp_v.dx, got.dx);
        errors++;
      end
      if (got.dy !== exp_v.dy) begin
        $display("%0t: dir_y exp %h got %h", $time, exp_v.dy, got.dy);
        errors++;
      end
      if (got.dz !== exp_v.dz) begin
        $display("%0t: dir_z exp %h got %h", $time, exp_v.dz, got.dz);
        errors++;
      end
      if (got.degen !== exp_v.degen) begin
        $display("%0t: degenerate exp %b got %b", $time, exp_v.degen, got.degen);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit quiet = 1'b0;
  longint unsigned cycles = 0;
  int sent = 0;
  dir_scoreboard sb = new();

  sdp_in_if #(.WORD_BITS(W)) spring_if ();
  sdp_out_if #(.WORD_BITS(W)) dir_if ();

  spring_direction_projection #(.WORD_BITS(W)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .spring_i(spring_if.sink),
    .dir_o   (dir_if.source)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    spring_if.valid = 1'b0;
    spring_if.first_x = '0; spring_if.first_y = '0; spring_if.first_z = '0;
    spring_if.second_x = '0; spring_if.second_y = '0; spring_if.second_z = '0;
    spring_if.rest_length = '0;
    dir_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Check each output beat against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && dir_if.valid && dir_if.ready)
      sb.check_vector({dir_if.dir_x, dir_if.dir_y, dir_if.dir_z, dir_if.degenerate});
  end

  // Receiver: stall in random bursts, never once the quiet phase starts.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 16);
        dir_if.ready = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        dir_if.ready = 1'b1;
        repeat ($urandom_range(0, 20)) begin
          @(negedge clk_i);
          if (quiet) break;
        end
      end
    end
  end

  task automatic send_spring(spring_t s);
    spring_if.first_x = s.ax; spring_if.first_y = s.ay; spring_if.first_z = s.az;
    spring_if.second_x = s.bx; spring_if.second_y = s.by; spring_if.second_z = s.bz;
    spring_if.rest_length = s.rest;
    spring_if.valid = 1'b1;
    do @(posedge clk_i); while (!spring_if.ready);
    sb.note_spring(s);
    sent++;
    @(negedge clk_i);
    // Hold valid high into the next beat unless a gap is drawn.
    if (!quiet && $urandom_range(0, 7) == 0) begin
      spring_if.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(W - 1){1'b1}}};
      1: return {1'b1, {(W - 1){1'b0}}};
      2: return W'($signed($urandom_range(0, 4000)) - 2000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [W-2:0] pick_rest();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return (W - 1)'($urandom_range(0, 1 << 18));
      default: return (W - 1)'($urandom());
    endcase
  endfunction

  function automatic spring_t random_spring();
    spring_t s;
    s.ax = pick_coord(); s.ay = pick_coord(); s.az = pick_coord();
    case ($urandom_range(0, 9))
      0: begin
        s.bx = s.ax; s.by = s.ay; s.bz = s.az;
      end
      1, 2, 3: begin
        // Short spring: small offsets from the first endpoint.
        s.bx = s.ax + W'($signed($urandom_range(0, 512)) - 256);
        s.by = s.ay + W'($signed($urandom_range(0, 512)) - 256);
        s.bz = s.az + W'($signed($urandom_range(0, 512)) - 256);
      end
      default: begin
        s.bx = pick_coord(); s.by = pick_coord(); s.bz = pick_coord();
      end
    endcase
    s.rest = pick_rest();
    return s;
  endfunction

  initial begin
    spring_t dir_list[20];
    logic [W-1:0] mx, mn;
    mx = {1'b0, {(W - 1){1'b1}}};
    mn = {1'b1, {(W - 1){1'b0}}};
    // Directed: coincident points, zero and full rest, extremes, each axis, both signs.
    dir_list = '{
      '{0, 0, 0, 0, 0, 0, '0},
      '{0, 0, 0, 0, 0, 0, '1},
      '{mx, mn, mx, mx, mn, mx, '1},
      '{mx, mx, mx, mn, mn, mn, '1},
      '{mn, mn, mn, mx, mx, mx, '1},
      '{mx, 0, 0, mn, 0, 0, '1},
      '{mn, 0, 0, mx, 0, 0, '1},
      '{0, mx, 0, 0, mn, 0, (W - 1)'('h10000)},
      '{0, 0, mn, 0, 0, mx, (W - 1)'('h10000)},
      '{1, 0, 0, 0, 0, 0, '1},
      '{0, -1, 0, 0, 0, 0, '1},
      '{0, 0, 1, 0, 0, 0, (W - 1)'(1)},
      '{1, 1, 0, 0, 0, 0, '1},
      '{1, 1, 1, 0, 0, 0, '1},
      '{mx, 1, 1, mn, 0, 0, '1},
      '{mx, mx, 0, mn, mn, 0, '1},
      '{'h30000, 'h40000, 0, 0, 0, 0, (W - 1)'('h50000)},
      '{'h30000, 'h40000, 0, 0, 0, 0, '0},
      '{-5, 7, -9, 5, -7, 9, (W - 1)'('h2aaaaaaa)},
      '{mx, mx, mx, mx, mx, mx, '1}
    };
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir_list[i]) send_spring(dir_list[i]);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) begin
        // Let the pipeline drain completely before resuming.
        spring_if.valid = 1'b0;
        wait_drained();
        @(negedge clk_i);
      end
      if (n == NUM_RANDOM - 200) quiet = 1'b1;
      send_spring(random_spring());
    end
    spring_if.valid = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d springs, checked %0d vectors, %0d degenerate.",
             sent, sb.checked, sb.degen_seen);
    $display("Covered extremes, coincident points, zero rest length and random stalls.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
